// File: rtl/assert_macros.svh
// assertion helpers used by the top-level rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHK_IMPLY(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("implication check failed");

// next-cycle implication, disabled during reset
`define CHK_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("next-cycle check failed");

`endif

// File: rtl/lrip_pkg.sv
`default_nettype none
package lrip_pkg;

	localparam int CW = 48;
	localparam int AW = 32;
	localparam int CORDIC_STEPS = 24;
	localparam int QW = 19;
	localparam int RW = 14;

	localparam logic signed [AW-1:0] HALF_TURN = 32'sd184320000;
	localparam logic signed [AW-1:0] QUARTER_TURN = 32'sd92160000;

	localparam int ATAN_TAB [CORDIC_STEPS] = '{
		46080000, 27202612, 14373113, 7296017, 3662166, 1832868, 916658, 458357,
		229182, 114591, 57296, 28648, 14324, 7162, 3581, 1790,
		895, 448, 224, 112, 56, 28, 14, 7
	};

	typedef enum logic [2:0] {
		REG_USE_RING   = 3'd0,
		REG_VERT_OFF   = 3'd1,
		REG_VERT_RES   = 3'd2,
		REG_HORIZ_RES  = 3'd3,
		REG_MIN_RANGE  = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		CAUSE_KEEP = 2'd0,
		CAUSE_ROW  = 2'd1,
		CAUSE_COL  = 2'd2,
		CAUSE_NEAR = 2'd3
	} cause_t;

	localparam logic [16:0] VERT_OFF_RST = 17'd15100;
	localparam logic [RW-1:0] VERT_RES_RST = 14'd2000;
	localparam logic [RW-1:0] HORIZ_RES_RST = 14'd200;
	localparam logic [15:0] MIN_RANGE_RST = 16'd1000;

endpackage
`default_nettype wire

// File: rtl/lidar_range_image_projection_top.sv
// one result per input point
// throughput: one point per cycle; set by the per-bit sqrt, cordic and divider stages
// the whole pipeline holds while a result waits under out_stall
// arst_n clears the valid bits and loads the register reset values
// no clearing pass after reset, points are taken on the first cycle
`default_nettype none
`include "assert_macros.svh"
module lidar_range_image_projection_top
	import lrip_pkg::*;
#(
	parameter int ROWS = 16,
	parameter int COLS = 1800
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [16:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [18:0] x_mm,
	input  logic signed [18:0] y_mm,
	input  logic signed [18:0] z_mm,
	input  logic [6:0]         ring,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               keep,
	output logic [1:0]         drop_cause,
	output logic [6:0]         row,
	output logic [11:0]        col,
	output logic [18:0]        flat_index,
	output logic [18:0]        range_mm
);

	localparam int XY_N = 31;
	localparam int RNG_N = 19;
	localparam int LAT = 2 + XY_N + CORDIC_STEPS + 1 + 1 + QW + 1;
	localparam int XYZ_DLY = 1 + XY_N;
	localparam int RNG_DLY = XY_N + CORDIC_STEPS + 1 + 1 + QW - RNG_N;
	localparam int RING_DLY = LAT - 2;
	localparam logic signed [21:0] COLS_S = 22'(COLS);
	localparam logic signed [21:0] HALF_S = 22'(COLS / 2);

	logic          use_ring_q;
	logic [16:0]   vert_off_q;
	logic [RW-1:0] vert_res_q;
	logic [RW-1:0] horiz_res_q;
	logic [15:0]   min_range_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_ring_q  <= 1'b0;
			vert_off_q  <= VERT_OFF_RST;
			vert_res_q  <= VERT_RES_RST;
			horiz_res_q <= HORIZ_RES_RST;
			min_range_q <= MIN_RANGE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_USE_RING:  use_ring_q  <= cfg_data[0];
				REG_VERT_OFF:  vert_off_q  <= cfg_data;
				REG_VERT_RES:  vert_res_q  <= cfg_data[RW-1:0];
				REG_HORIZ_RES: horiz_res_q <= cfg_data[RW-1:0];
				REG_MIN_RANGE: min_range_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic [RW-1:0] vres;
	logic [RW-1:0] hres;
	assign vres = (vert_res_q == '0) ? RW'(1) : vert_res_q;
	assign hres = (horiz_res_q == '0) ? RW'(1) : horiz_res_q;

	// global advance: everything moves unless a result is held
	logic adv;
	logic vld_s [LAT];
	assign adv       = !vld_s[LAT-1] || !out_stall;
	assign in_stall  = !adv;
	assign out_valid = vld_s[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < LAT; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// squares and sums
	logic signed [37:0] xx;
	logic signed [37:0] yy;
	logic signed [37:0] zz;
	assign xx = 38'(x_mm) * 38'(x_mm);
	assign yy = 38'(y_mm) * 38'(y_mm);
	assign zz = 38'(z_mm) * 38'(z_mm);

	logic [18:0] x_s1;
	logic [18:0] y_s1;
	logic [18:0] z_s1;
	logic [6:0]  ring_s1;
	logic [36:0] x2_s1;
	logic [36:0] y2_s1;
	logic [36:0] z2_s1;
	logic [37:0] xy2_s2;
	logic [37:0] r2_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= x_mm;
			y_s1    <= y_mm;
			z_s1    <= z_mm;
			ring_s1 <= ring;
			x2_s1   <= xx[36:0];
			y2_s1   <= yy[36:0];
			z2_s1   <= zz[36:0];
			xy2_s2  <= {1'b0, x2_s1} + {1'b0, y2_s1};
			r2_s2   <= {1'b0, x2_s1} + {1'b0, y2_s1} + {1'b0, z2_s1};
		end
	end

	logic [XY_N-1:0]  rxy;
	logic [RNG_N-1:0] rng;
	logic [RNG_N-1:0] rng_d;

	lrip_isqrt #(.N(XY_N)) u_sqrt_xy (
		.clk  (clk),
		.en   (adv),
		.din  ({xy2_s2, 24'b0}),
		.root (rxy)
	);

	lrip_isqrt #(.N(RNG_N)) u_sqrt_rng (
		.clk  (clk),
		.en   (adv),
		.din  (r2_s2),
		.root (rng)
	);

	lrip_delay #(.W(RNG_N), .D(RNG_DLY)) u_dly_rng (
		.clk  (clk),
		.en   (adv),
		.din  (rng),
		.dout (rng_d)
	);

	logic [56:0] xyz_d;
	lrip_delay #(.W(57), .D(XYZ_DLY)) u_dly_xyz (
		.clk  (clk),
		.en   (adv),
		.din  ({x_s1, y_s1, z_s1}),
		.dout (xyz_d)
	);

	logic [6:0] ring_d;
	lrip_delay #(.W(7), .D(RING_DLY)) u_dly_ring (
		.clk  (clk),
		.en   (adv),
		.din  (ring_s1),
		.dout (ring_d)
	);

	logic signed [CW-1:0] elev_x;
	logic signed [CW-1:0] elev_y;
	logic signed [CW-1:0] az_x;
	logic signed [CW-1:0] az_y;
	assign elev_x = {5'b0, rxy, 12'b0};
	assign elev_y = {{5{xyz_d[18]}}, xyz_d[18:0], 24'b0};
	assign az_y   = {{5{xyz_d[56]}}, xyz_d[56:38], 24'b0};
	assign az_x   = {{5{xyz_d[37]}}, xyz_d[37:19], 24'b0};

	logic signed [AW-1:0] elev;
	logic signed [AW-1:0] az;

	lrip_cordic u_cordic_elev (
		.clk  (clk),
		.en   (adv),
		.x_in (elev_x),
		.y_in (elev_y),
		.ang  (elev)
	);

	lrip_cordic u_cordic_az (
		.clk  (clk),
		.en   (adv),
		.x_in (az_x),
		.y_in (az_y),
		.ang  (az)
	);

	// divider operands, scaled down by the 1024 units per millidegree
	logic signed [AW-1:0] num_e;
	logic signed [AW-1:0] abs_e;
	logic signed [AW-1:0] num_c;
	logic signed [AW-1:0] abs_c;
	logic signed [AW-1:0] sum_c;
	assign num_e = elev + $signed({5'b0, vert_off_q, 10'b0});
	assign abs_e = num_e[AW-1] ? -num_e : num_e;
	assign num_c = az - QUARTER_TURN;
	assign abs_c = num_c[AW-1] ? -num_c : num_c;
	assign sum_c = abs_c + $signed({9'b0, hres, 9'b0});

	logic [QW-1:0] dvd_e_s59;
	logic [QW-1:0] dvd_c_s59;
	logic          neg_e_s59;
	logic          neg_c_s59;

	always_ff @(posedge clk) begin
		if (adv) begin
			dvd_e_s59 <= abs_e[28:10];
			dvd_c_s59 <= sum_c[28:10];
			neg_e_s59 <= num_e[AW-1];
			neg_c_s59 <= num_c[AW-1];
		end
	end

	logic [QW-1:0] q_e;
	logic [QW-1:0] q_c;
	logic [1:0]    neg_d;

	lrip_div u_div_row (
		.clk      (clk),
		.en       (adv),
		.dividend (dvd_e_s59),
		.divisor  (vres),
		.quot     (q_e)
	);

	lrip_div u_div_col (
		.clk      (clk),
		.en       (adv),
		.dividend (dvd_c_s59),
		.divisor  (hres),
		.quot     (q_c)
	);

	lrip_delay #(.W(2), .D(QW)) u_dly_neg (
		.clk  (clk),
		.en   (adv),
		.din  ({neg_e_s59, neg_c_s59}),
		.dout (neg_d)
	);

	// bounds checks and flat index
	logic              row_bad;
	logic [6:0]        row_v;
	logic signed [21:0] c_mag;
	logic signed [21:0] col_a;
	logic signed [21:0] col_b;
	logic              col_bad;
	logic              near;
	cause_t            cause;
	logic [18:0]       flat_v;

	always_comb begin
		if (use_ring_q) begin
			row_bad = {1'b0, ring_d} >= 8'(ROWS);
			row_v   = ring_d;
		end else begin
			row_bad = (neg_d[1] && (q_e != '0)) || (q_e >= QW'(ROWS));
			row_v   = q_e[6:0];
		end
		c_mag   = $signed({3'b0, q_c});
		col_a   = neg_d[0] ? HALF_S + c_mag : HALF_S - c_mag;
		col_b   = (col_a >= COLS_S) ? col_a - COLS_S : col_a;
		col_bad = col_b[21] || (col_b >= COLS_S);
		near    = rng_d < {3'b0, min_range_q};
		if (row_bad) begin
			cause = CAUSE_ROW;
		end else if (col_bad) begin
			cause = CAUSE_COL;
		end else if (near) begin
			cause = CAUSE_NEAR;
		end else begin
			cause = CAUSE_KEEP;
		end
		flat_v = 19'(col_b[11:0]) + 19'(row_v) * 19'(COLS);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			keep       <= cause == CAUSE_KEEP;
			drop_cause <= cause;
			row        <= (cause == CAUSE_KEEP) ? row_v : '0;
			col        <= (cause == CAUSE_KEEP) ? col_b[11:0] : '0;
			flat_index <= (cause == CAUSE_KEEP) ? flat_v : '0;
			range_mm   <= rng_d;
		end
	end

	`CHK_IMPLY(a_drop_zero, clk, arst_n, out_valid && !keep,
		(row == '0) && (col == '0) && (flat_index == '0))
	`CHK_IMPLY(a_keep_bounds, clk, arst_n, out_valid && keep,
		({1'b0, row} < 8'(ROWS)) && ({1'b0, col} < 13'(COLS)) && (drop_cause == CAUSE_KEEP))
	`CHK_NEXT(a_stall_holds, clk, arst_n, in_stall && out_stall, out_valid)

endmodule
`default_nettype wire

// File: rtl/lrip_delay.sv
`default_nettype none
module lrip_delay #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] tap_s [D];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= din;
			for (int k = 1; k < D; k++) begin
				tap_s[k] <= tap_s[k-1];
			end
		end
	end

	assign dout = tap_s[D-1];

endmodule
`default_nettype wire

// File: rtl/lrip_isqrt.sv
`default_nettype none
module lrip_isqrt #(
	parameter int N = 19
) (
	input  logic           clk,
	input  logic           en,
	input  logic [2*N-1:0] din,
	output logic [N-1:0]   root
);

	logic [N+1:0]   rem_s  [N];
	logic [N-1:0]   root_s [N];
	logic [2*N-1:0] rest_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [N+1:0]   rem_p;
		logic [N-1:0]   root_p;
		logic [2*N-1:0] rest_p;
		logic [N+1:0]   rem_n;
		logic [N+1:0]   trial;
		logic           ge;

		if (k == 0) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign rest_p = din;
		end else begin : g_next
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign rest_p = rest_s[k-1];
		end

		// bring down two bits, try root*4+1
		assign rem_n = {rem_p[N-1:0], rest_p[2*N-1 -: 2]};
		assign trial = {root_p, 2'b01};
		assign ge    = rem_n >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? rem_n - trial : rem_n;
				root_s[k] <= {root_p[N-2:0], ge};
				rest_s[k] <= {rest_p[2*N-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[N-1];

endmodule
`default_nettype wire

// File: rtl/lrip_cordic.sv
`default_nettype none
module lrip_cordic
	import lrip_pkg::*;
(
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [CW-1:0] x_in,
	input  logic signed [CW-1:0] y_in,
	output logic signed [AW-1:0] ang
);

	logic signed [CW-1:0] x_s0;
	logic signed [CW-1:0] y_s0;
	logic signed [AW-1:0] a_s0;
	logic                 z_s0;

	logic signed [CW-1:0] x_s [CORDIC_STEPS];
	logic signed [CW-1:0] y_s [CORDIC_STEPS];
	logic signed [AW-1:0] a_s [CORDIC_STEPS];
	logic                 z_s [CORDIC_STEPS];

	// left half plane: rotate by a half turn first
	always_ff @(posedge clk) begin
		if (en) begin
			z_s0 <= (x_in == '0) && (y_in == '0);
			if (x_in[CW-1]) begin
				x_s0 <= -x_in;
				y_s0 <= -y_in;
				a_s0 <= y_in[CW-1] ? -HALF_TURN : HALF_TURN;
			end else begin
				x_s0 <= x_in;
				y_s0 <= y_in;
				a_s0 <= '0;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam logic signed [AW-1:0] TAB = AW'(ATAN_TAB[i]);
		logic signed [CW-1:0] xp;
		logic signed [CW-1:0] yp;
		logic signed [AW-1:0] ap;
		logic                 zp;

		if (i == 0) begin : g_first
			assign xp = x_s0;
			assign yp = y_s0;
			assign ap = a_s0;
			assign zp = z_s0;
		end else begin : g_next
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign ap = a_s[i-1];
			assign zp = z_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				z_s[i] <= zp;
				if (!yp[CW-1]) begin
					x_s[i] <= xp + (yp >>> i);
					y_s[i] <= yp - (xp >>> i);
					a_s[i] <= ap + TAB;
				end else begin
					x_s[i] <= xp - (yp >>> i);
					y_s[i] <= yp + (xp >>> i);
					a_s[i] <= ap - TAB;
				end
			end
		end
	end

	assign ang = z_s[CORDIC_STEPS-1] ? '0 : a_s[CORDIC_STEPS-1];

endmodule
`default_nettype wire

// File: rtl/lrip_div.sv
`default_nettype none
module lrip_div
	import lrip_pkg::*;
(
	input  logic          clk,
	input  logic          en,
	input  logic [QW-1:0] dividend,
	input  logic [RW-1:0] divisor,
	output logic [QW-1:0] quot
);

	logic [RW-1:0] rem_s  [QW];
	logic [QW-1:0] rest_s [QW];
	logic [QW-1:0] q_s    [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [RW-1:0] rem_p;
		logic [QW-1:0] rest_p;
		logic [QW-1:0] q_p;
		logic [RW:0]   rem_n;
		logic [RW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_p  = '0;
			assign rest_p = dividend;
			assign q_p    = '0;
		end else begin : g_next
			assign rem_p  = rem_s[k-1];
			assign rest_p = rest_s[k-1];
			assign q_p    = q_s[k-1];
		end

		assign rem_n = {rem_p, rest_p[QW-1]};
		assign ge    = rem_n >= {1'b0, divisor};
		assign diff  = rem_n - {1'b0, divisor};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[RW-1:0] : rem_n[RW-1:0];
				rest_s[k] <= {rest_p[QW-2:0], 1'b0};
				q_s[k]    <= {q_p[QW-2:0], ge};
			end
		end
	end

	assign quot = q_s[QW-1];

endmodule
`default_nettype wire

// File: bench/lidar_range_image_projection_top_test.sv
`default_nettype none
module lidar_range_image_projection_top_test;
	import lrip_pkg::*;

	localparam int ROWS = 16;
	localparam int COLS = 1800;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 90;
	localparam int HOLD_CYCLES = 300;
	localparam logic [2:0] REG_SPARE = 3'd7;
	localparam longint MDEG = 1024;

	typedef struct {
		logic        keep;
		cause_t      cause;
		logic [6:0]  row;
		logic [11:0] col;
		logic [18:0] flat;
		logic [18:0] rng_mm;
	} cell_t;

	class cell_board;
		cell_t       pending_q[$];
		logic        ring_mode;
		logic [16:0] vert_off;
		logic [13:0] vert_res;
		logic [13:0] horiz_res;
		logic [15:0] min_range;
		int          errors;
		int          checked;
		int          cause_hits[4];

		function void load_reset();
			ring_mode = 1'b0;
			vert_off = VERT_OFF_RST;
			vert_res = VERT_RES_RST;
			horiz_res = HORIZ_RES_RST;
			min_range = MIN_RANGE_RST;
		endfunction

		function void set_reg(logic [2:0] idx, logic [16:0] v);
			case (idx)
				REG_USE_RING: ring_mode = v[0];
				REG_VERT_OFF: vert_off = v;
				REG_VERT_RES: vert_res = v[13:0];
				REG_HORIZ_RES: horiz_res = v[13:0];
				REG_MIN_RANGE: min_range = v[15:0];
				default: ;
			endcase
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned res;
			longint unsigned b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v)
				b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		// vectoring cordic, result in 1/1024 millidegree
		function longint vector_angle(longint yy, longint xx);
			longint ang;
			longint nx;
			longint ny;
			ang = 0;
			if (xx == 0 && yy == 0)
				return 0;
			if (xx < 0) begin
				ang = (yy >= 0) ? longint'(HALF_TURN) : -longint'(HALF_TURN);
				xx = -xx;
				yy = -yy;
			end
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				if (yy >= 0) begin
					nx = xx + (yy >>> i);
					ny = yy - (xx >>> i);
					ang = ang + ATAN_TAB[i];
				end else begin
					nx = xx - (yy >>> i);
					ny = yy + (xx >>> i);
					ang = ang - ATAN_TAB[i];
				end
				xx = nx;
				yy = ny;
			end
			return ang;
		endfunction

		function void note(logic signed [18:0] px, logic signed [18:0] py,
				logic signed [18:0] pz, logic [6:0] pring);
			longint x, y, z, xy2, rxy, elev, resv, r, az, n, d, c, cl;
			longint unsigned rng_v;
			cell_t e;
			x = px;
			y = py;
			z = pz;
			xy2 = x * x + y * y;
			rng_v = int_sqrt(longint'(xy2 + z * z));
			if (ring_mode) begin
				r = pring;
			end else begin
				rxy = int_sqrt(xy2 << 24);
				elev = vector_angle(z * (64'sd1 << 24), rxy * 4096);
				resv = (vert_res == 0) ? 1 : longint'(vert_res);
				r = (elev + longint'(vert_off) * MDEG) / (resv * MDEG);
			end
			cl = 0;
			e.cause = CAUSE_KEEP;
			if (r < 0 || r >= ROWS) begin
				e.cause = CAUSE_ROW;
			end else begin
				az = vector_angle(x * (64'sd1 << 24), y * (64'sd1 << 24));
				d = ((horiz_res == 0) ? 1 : longint'(horiz_res)) * MDEG;
				n = az - longint'(QUARTER_TURN);
				c = (n >= 0) ? (2 * n + d) / (2 * d) : -((-2 * n + d) / (2 * d));
				cl = COLS / 2 - c;
				if (cl >= COLS)
					cl = cl - COLS;
				if (cl < 0 || cl >= COLS)
					e.cause = CAUSE_COL;
				else if (rng_v < longint'(min_range))
					e.cause = CAUSE_NEAR;
			end
			e.keep = (e.cause == CAUSE_KEEP);
			e.row = e.keep ? r[6:0] : '0;
			e.col = e.keep ? cl[11:0] : '0;
			e.flat = e.keep ? 19'(cl + r * COLS) : '0;
			e.rng_mm = rng_v[18:0];
			pending_q = {pending_q, e};
		endfunction

		function void check(cell_t got);
			cell_t e;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result, expected none actual cause %0d",
					$time, got.cause);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			checked++;
			cause_hits[e.cause]++;
			if (got.keep !== e.keep) begin
				$display("%0t: keep expected %0d actual %0d", $time, e.keep, got.keep);
				errors++;
			end
			if (got.cause !== e.cause) begin
				$display("%0t: drop_cause expected %0d actual %0d", $time, e.cause, got.cause);
				errors++;
			end
			if (got.row !== e.row) begin
				$display("%0t: row expected %0d actual %0d", $time, e.row, got.row);
				errors++;
			end
			if (got.col !== e.col) begin
				$display("%0t: col expected %0d actual %0d", $time, e.col, got.col);
				errors++;
			end
			if (got.flat !== e.flat) begin
				$display("%0t: flat_index expected %0d actual %0d", $time, e.flat, got.flat);
				errors++;
			end
			if (got.rng_mm !== e.rng_mm) begin
				$display("%0t: range_mm expected %0d actual %0d", $time, e.rng_mm, got.rng_mm);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [16:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic signed [18:0] x_mm;
	logic signed [18:0] y_mm;
	logic signed [18:0] z_mm;
	logic [6:0]         ring;
	logic               out_valid;
	logic               out_stall;
	logic               keep;
	logic [1:0]         drop_cause;
	logic [6:0]         row;
	logic [11:0]        col;
	logic [18:0]        flat_index;
	logic [18:0]        range_mm;

	cell_board board;
	logic      hold_req;
	int        quiet;
	int        points_sent;

	lidar_range_image_projection_top #(.ROWS(ROWS), .COLS(COLS)) uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.x_mm(x_mm), .y_mm(y_mm), .z_mm(z_mm), .ring(ring),
		.out_valid(out_valid), .out_stall(out_stall), .keep(keep),
		.drop_cause(drop_cause), .row(row), .col(col),
		.flat_index(flat_index), .range_mm(range_mm)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cell_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.keep = keep;
			got.cause = cause_t'(drop_cause);
			got.row = row;
			got.col = col;
			got.flat = flat_index;
			got.rng_mm = range_mm;
			board.check(got);
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, board.pending_q.size());
			$display("lidar_range_image_projection_top_test failed");
			$finish;
		end
	end

	// receiver
	initial begin
		int r;
		int len;
		logic v;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					v = 1'b0;
					len = $urandom_range(1, 20);
				end else if (r < 95) begin
					v = 1'b1;
					len = $urandom_range(1, 3);
				end else begin
					v = 1'b1;
					len = $urandom_range(20, 60);
				end
				out_stall <= v;
				repeat (len - 1) @(negedge clk);
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [16:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		board.set_reg(idx, v);
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_point(logic signed [18:0] px, logic signed [18:0] py,
			logic signed [18:0] pz, logic [6:0] pring);
		@(negedge clk);
		in_valid <= 1'b1;
		x_mm <= px;
		y_mm <= py;
		z_mm <= pz;
		ring <= pring;
		do @(posedge clk); while (in_stall);
		board.note(px, py, pz, pring);
		points_sent++;
	endtask

	task automatic sender_gap(bit allow);
		int r;
		int len;
		r = $urandom_range(0, 99);
		if (!allow || r < 60)
			return;
		len = (r < 90) ? $urandom_range(1, 3) : $urandom_range(5, 40);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (len - 1) @(negedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic int srand(int a);
		return int'($urandom_range(0, 2 * a)) - a;
	endfunction

	task automatic random_point(bit ring_mode);
		int r;
		int rad;
		int h;
		logic signed [18:0] px, py, pz;
		logic [6:0] pr;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			rad = ($urandom_range(0, 3) == 0) ? 2000 : $urandom_range(1000, 120000);
			px = 19'(srand(rad));
			py = 19'(srand(rad));
			h = (px < 0 ? -int'(px) : int'(px)) + (py < 0 ? -int'(py) : int'(py));
			pz = 19'(srand(h / 4 + 1));
		end else if (r < 70) begin
			px = 19'(srand(1500));
			py = 19'(srand(1500));
			pz = 19'(srand(500));
		end else begin
			px = 19'($urandom());
			py = 19'($urandom());
			pz = 19'($urandom());
		end
		pr = (ring_mode && $urandom_range(0, 4) != 0) ? 7'($urandom_range(0, ROWS - 1))
			: 7'($urandom_range(0, 127));
		send_point(px, py, pz, pr);
	endtask

	task automatic directed_points();
		send_point(19'sd0, 19'sd0, 19'sd0, 7'd0);
		send_point(19'sd262143, 19'sd262143, 19'sd262143, 7'd127);
		send_point(19'sh40000, 19'sh40000, 19'sh40000, 7'd0);
		send_point(19'sh40000, 19'sd0, 19'sd0, 7'd15);
		send_point(19'sd0, 19'sh40000, 19'sd0, 7'd16);
		send_point(19'sd0, 19'sd0, 19'sd262143, 7'd1);
		send_point(19'sd0, 19'sd0, 19'sh40000, 7'd2);
		send_point(19'sd5000, 19'sd0, 19'sd0, 7'd3);
		send_point(19'sd0, 19'sd5000, 19'sd100, 7'd4);
		send_point(-19'sd5000, 19'sd0, -19'sd100, 7'd5);
		send_point(19'sd0, -19'sd5000, 19'sd0, 7'd6);
		send_point(-19'sd5000, -19'sd1, 19'sd0, 7'd7);
		send_point(19'sd999, 19'sd0, 19'sd0, 7'd8);
		send_point(19'sd1000, 19'sd0, 19'sd0, 7'd9);
		send_point(19'sd3000, 19'sd3000, 19'sd0, 7'd10);
		send_point(19'sd10000, 19'sd0, -19'sd2700, 7'd11);
		send_point(19'sd10000, 19'sd0, 19'sd2990, 7'd14);
	endtask

	task automatic set_all(logic m, logic [16:0] off, logic [16:0] vr,
			logic [16:0] hr, logic [16:0] mr);
		write_reg(REG_USE_RING, {16'd0, m});
		write_reg(REG_VERT_OFF, off);
		write_reg(REG_VERT_RES, vr);
		write_reg(REG_HORIZ_RES, hr);
		write_reg(REG_MIN_RANGE, mr);
	endtask

	initial begin
		board = new();
		board.load_reset();
		hold_req = 1'b0;
		quiet = 0;
		points_sent = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_USE_RING;
		cfg_data = '0;
		in_valid = 1'b0;
		x_mm = '0;
		y_mm = '0;
		z_mm = '0;
		ring = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < 6; ph++) begin
			if (ph > 0) begin
				wait_drained();
				repeat (DRAIN_CYCLES) @(posedge clk);
				case (ph)
					1: set_all(1'b1, 17'd90000, 17'd10000, 17'd10000, 17'd0);
					2: set_all(1'b0, 17'd0, 17'd0, 17'd0, 17'd65535);
					3: set_all(1'b0, 17'd90000, 17'd10000, 17'd1, 17'd0);
					4: begin
						set_all(1'b0, 17'($urandom_range(0, 90000)),
							17'($urandom_range(1, 10000)),
							17'($urandom_range(1, 10000)),
							17'($urandom_range(0, 65535)));
						write_reg(REG_SPARE, 17'($urandom()));
					end
					default: set_all(1'b1, 17'd15100, 17'd2000, 17'd200, 17'd1000);
				endcase
				end_writes();
			end
			if (ph < 2)
				directed_points();
			if (ph == 2)
				hold_req = 1'b1;
			for (int i = 0; i < 250; i++) begin
				if (ph == 3 && i == 100)
					wait_drained();
				random_point(board.ring_mode);
				sender_gap(ph != 2 || i > 150);
			end
		end
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d points sent, %0d results checked over six register settings",
			points_sent, board.checked);
		$display("kept %0d, row drops %0d, column drops %0d, near drops %0d",
			board.cause_hits[CAUSE_KEEP], board.cause_hits[CAUSE_ROW],
			board.cause_hits[CAUSE_COL], board.cause_hits[CAUSE_NEAR]);
		if (board.errors == 0 && board.pending_q.size() == 0)
			$display("lidar_range_image_projection_top_test passed");
		else
			$display("lidar_range_image_projection_top_test failed");
		$finish;
	end
endmodule
`default_nettype wire

// File: files.f
+incdir+rtl
rtl/lrip_pkg.sv
rtl/lrip_delay.sv
rtl/lrip_isqrt.sv
rtl/lrip_cordic.sv
rtl/lrip_div.sv
rtl/lidar_range_image_projection_top.sv
bench/lidar_range_image_projection_top_test.sv
